[src/pcsd_pkg.sv]
`timescale 1ns / 1ps
package pcsd_pkg;

    localparam int MAX_ITEMS  = 128;
    localparam int MAX_COLORS = 32;
    localparam int COST_BITS  = 16;

    localparam int RW  = $clog2(MAX_ITEMS);          // row (run count) index
    localparam int KW  = $clog2(MAX_COLORS);         // color index
    localparam int NCW = 6;                          // num_colors register
    localparam int TGW = 8;                          // target_runs register
    localparam int ICW = $clog2(MAX_ITEMS + 1);      // item counter
    localparam int VW  = RW + COST_BITS + 1;         // table entry, all ones = infinity
    localparam int AW  = RW + KW + 1;                // table address, layer on top

    localparam logic [VW-1:0] INF_COST = '1;

    localparam logic CFG_NUM_COLORS  = 1'b0;
    localparam logic CFG_TARGET_RUNS = 1'b1;

    typedef struct packed {
        logic [MAX_COLORS-1:0][COST_BITS-1:0] costs;
        logic [5:0]                           existing;
        logic [NCW-1:0]                       nc;
        logic [RW-1:0]                        idx;
        logic                                 do_upd;
        logic                                 last;
        logic                                 ovf;
    } t_item;

    typedef enum logic [2:0] {
        B_IDLE,
        B_UPD,
        B_UWAIT,
        B_SCAN,
        B_SWAIT,
        B_OUT
    } t_bstate;

endpackage

[src/paint_cost_segment_dp_top.sv]
`timescale 1ns / 1ps
// Least cost to paint a row of items into exactly target_runs runs of equal color.
// Each item arrives as num_colors transactions, one per color, accepted one per cycle
// while o_stall is low. After an item's final transaction the back end walks the
// run-count by color table, one cell per cycle through the table memory's single read
// and single write port: (item_index + 2) rows, capped at 128, times 32 colors. The
// final item of a row adds a scan of the target row's 32 cells, when target_runs is in
// range, before the result transaction is offered. A two-item queue between the entry
// collector and the table engine keeps the input open while an update runs; o_stall
// rises only when both slots are taken. The table memory needs no clearing pass after reset.
module paint_cost_segment_dp_top
    import pcsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [5:0]  i_existing_color,
    input  logic [15:0] i_paint_cost,
    input  logic        i_last_item,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [22:0] o_min_cost,
    output logic        o_found,
    output logic        o_overflow,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic [NCW-1:0] r_num_colors;
    logic [TGW-1:0] r_target_runs;
    logic           q_push, q_full, q_pop, q_valid;
    t_item          q_in, q_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_colors  <= NCW'(1);
            r_target_runs <= TGW'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NUM_COLORS:  r_num_colors  <= i_cfg_data[NCW-1:0];
                CFG_TARGET_RUNS: r_target_runs <= i_cfg_data;
                default:         r_target_runs <= r_target_runs;
            endcase
        end
    end

    pcsd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_existing_color (i_existing_color),
        .i_paint_cost     (i_paint_cost),
        .i_last_item      (i_last_item),
        .i_num_colors     (r_num_colors),
        .i_q_full         (q_full),
        .o_q_push         (q_push),
        .o_q_item         (q_in)
    );

    pcsd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out)
    );

    pcsd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_out),
        .o_q_pop       (q_pop),
        .i_target_runs (r_target_runs),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_min_cost    (o_min_cost),
        .o_found       (o_found),
        .o_overflow    (o_overflow)
    );

endmodule

[src/pcsd_front.sv]
`timescale 1ns / 1ps
module pcsd_front
    import pcsd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [5:0]           i_existing_color,
    input  logic [15:0]          i_paint_cost,
    input  logic                 i_last_item,
    input  logic [NCW-1:0]       i_num_colors,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output t_item                o_q_item
);

    logic [MAX_COLORS-1:0][COST_BITS-1:0] r_buf, n_buf;
    logic [KW-1:0]  r_ci;
    logic [ICW-1:0] r_item;
    logic           r_tm;
    logic [NCW-1:0] nc;
    logic           accept, final_e, upd;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;

    always_comb begin
        if (i_num_colors == '0) begin
            nc = NCW'(1);
        end else if (int'(i_num_colors) > MAX_COLORS) begin
            nc = NCW'(MAX_COLORS);
        end else begin
            nc = i_num_colors;
        end
    end

    always_comb begin
        n_buf        = r_buf;
        n_buf[r_ci]  = i_paint_cost[COST_BITS-1:0];
    end

    assign final_e = (int'(r_ci) + 1) >= int'(nc);
    assign upd     = !r_tm && (int'(r_item) < MAX_ITEMS);

    assign o_q_push = accept && final_e && (upd || i_last_item);

    always_comb begin
        o_q_item.costs    = n_buf;
        o_q_item.existing = i_existing_color;
        o_q_item.nc       = nc;
        o_q_item.idx      = r_item[RW-1:0];
        o_q_item.do_upd   = upd;
        o_q_item.last     = i_last_item;
        o_q_item.ovf      = !upd;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf <= n_buf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ci   <= '0;
            r_item <= '0;
            r_tm   <= 1'b0;
        end else if (accept) begin
            if (!final_e) begin
                r_ci <= r_ci + KW'(1);
            end else begin
                r_ci <= '0;
                if (i_last_item) begin
                    r_item <= '0;
                    r_tm   <= 1'b0;
                end else if (upd) begin
                    r_item <= r_item + ICW'(1);
                end else begin
                    r_tm <= 1'b1;
                end
            end
        end
    end

endmodule

[src/pcsd_fifo.sv]
`timescale 1ns / 1ps
module pcsd_fifo
    import pcsd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item      r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("transaction pushed into full queue");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

[src/pcsd_back.sv]
`timescale 1ns / 1ps
module pcsd_back
    import pcsd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  t_item           i_q_item,
    output logic            o_q_pop,
    input  logic [TGW-1:0]  i_target_runs,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [22:0]     o_min_cost,
    output logic            o_found,
    output logic            o_overflow
);

    localparam logic [KW-1:0] KMAX = KW'(MAX_COLORS - 1);

    t_bstate r_state, n_state;

    logic [VW-1:0] r_mem [2**AW];
    logic [VW-1:0] r_rd;
    logic          r_layer;
    logic [RW-1:0] r_ir, r_sr;
    logic [KW-1:0] r_ik, r_sk;
    logic          r_sv, r_sscan;

    logic [VW-1:0] r_bp, r_sp, r_ab, r_as, r_sbest;
    logic [KW-1:0] r_bk, r_ak;
    logic          r_bkv, r_akv;

    logic          r_out_valid, r_out_found, r_out_ovf;
    logic [22:0]   r_out_cost;

    logic          issue, out_free, out_load, upd_done, scan_done, tr_ok;
    logic [RW-1:0] row_last, scan_row;
    logic [AW-1:0] raddr, waddr;
    logic          we;
    logic [VW-1:0] wdata;
    logic [VW-1:0] same, other, v, addc;
    logic [VW:0]   sum;
    logic          live, colok;
    logic [VW-1:0] n_ab, n_as;
    logic [KW-1:0] n_ak;
    logic          n_akv;

    assign row_last  = (int'(i_q_item.idx) == MAX_ITEMS - 1) ? i_q_item.idx
                                                             : i_q_item.idx + RW'(1);
    assign scan_row  = RW'(i_target_runs - TGW'(1));
    assign tr_ok     = (i_target_runs != '0) && (int'(i_target_runs) <= MAX_ITEMS)
                       && (int'(i_target_runs) - 1 <= int'(row_last));
    assign upd_done  = (r_ir == row_last) && (r_ik == KMAX);
    assign scan_done = (r_ik == KMAX);
    assign out_free  = !r_out_valid || !i_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    n_state = i_q_item.do_upd ? B_UPD : B_OUT;
                end
            end
            B_UPD: begin
                if (upd_done) begin
                    n_state = B_UWAIT;
                end
            end
            B_UWAIT: begin
                if (!i_q_item.last) begin
                    n_state = B_IDLE;
                end else if (tr_ok) begin
                    n_state = B_SCAN;
                end else begin
                    n_state = B_OUT;
                end
            end
            B_SCAN: begin
                if (scan_done) begin
                    n_state = B_SWAIT;
                end
            end
            B_SWAIT: n_state = B_OUT;
            B_OUT: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        issue    = 1'b0;
        o_q_pop  = 1'b0;
        out_load = 1'b0;
        raddr    = {r_layer, r_ir, r_ik};
        case (r_state)
            B_UPD:   issue = 1'b1;
            B_SCAN: begin
                issue = 1'b1;
                raddr = {r_layer, scan_row, r_ik};
            end
            B_UWAIT: o_q_pop = !i_q_item.last;
            B_OUT: begin
                out_load = out_free;
                o_q_pop  = out_free;
            end
            default: issue = 1'b0;
        endcase
    end

    // cell update on the data returning from the table
    always_comb begin
        live  = (r_sr <= i_q_item.idx);
        colok = (int'(r_sk) < int'(i_q_item.nc))
                && (int'(i_q_item.existing) <= int'(i_q_item.nc))
                && ((i_q_item.existing == 6'd0)
                    || (int'(r_sk) == int'(i_q_item.existing) - 1));
        same  = (i_q_item.idx == '0) ? INF_COST : r_rd;
        if (r_sr == '0) begin
            other = INF_COST;
        end else begin
            other = (r_bkv && r_sk == r_bk) ? r_sp : r_bp;
        end
        if (i_q_item.idx == '0) begin
            v = '0;
        end else begin
            v = (same < other) ? same : other;
        end
        addc  = (i_q_item.existing == 6'd0) ? VW'(i_q_item.costs[r_sk]) : '0;
        sum   = {1'b0, v} + {1'b0, addc};
        if (!live || !colok || v == INF_COST || sum >= {1'b0, INF_COST}) begin
            wdata = INF_COST;
        end else begin
            wdata = sum[VW-1:0];
        end
        we    = r_sv && !r_sscan;
        waddr = {!r_layer, r_sr, r_sk};

        // best and second best of this row feed the next row
        n_ab  = r_ab;
        n_as  = r_as;
        n_ak  = r_ak;
        n_akv = r_akv;
        if (int'(r_sk) < int'(i_q_item.nc)) begin
            if (r_rd < r_ab) begin
                n_as  = r_ab;
                n_ab  = r_rd;
                n_ak  = r_sk;
                n_akv = 1'b1;
            end else if (r_rd < r_as) begin
                n_as = r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (issue) begin
            r_rd <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sr <= r_ir;
        r_sk <= r_ik;
        if (r_state == B_IDLE) begin
            r_ir    <= '0;
            r_ik    <= '0;
            r_bp    <= INF_COST;
            r_sp    <= INF_COST;
            r_bkv   <= 1'b0;
            r_ab    <= INF_COST;
            r_as    <= INF_COST;
            r_akv   <= 1'b0;
            r_sbest <= INF_COST;
        end else begin
            if (issue) begin
                r_ik <= r_ik + KW'(1);
                if (r_state == B_UPD && r_ik == KMAX) begin
                    r_ir <= r_ir + RW'(1);
                end
            end
            if (r_state == B_UWAIT) begin
                r_ik <= '0;
            end
            if (r_sv && !r_sscan) begin
                if (r_sk == KMAX) begin
                    r_bp  <= n_ab;
                    r_sp  <= n_as;
                    r_bk  <= n_ak;
                    r_bkv <= n_akv;
                    r_ab  <= INF_COST;
                    r_as  <= INF_COST;
                    r_akv <= 1'b0;
                end else begin
                    r_ab  <= n_ab;
                    r_as  <= n_as;
                    r_ak  <= n_ak;
                    r_akv <= n_akv;
                end
            end
            if (r_sv && r_sscan && int'(r_sk) < int'(i_q_item.nc) && r_rd < r_sbest) begin
                r_sbest <= r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_ovf   <= i_q_item.ovf;
            r_out_found <= !i_q_item.ovf && (r_sbest != INF_COST);
            r_out_cost  <= (!i_q_item.ovf && r_sbest != INF_COST) ? 23'(r_sbest) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_layer     <= 1'b0;
            r_sv        <= 1'b0;
            r_sscan     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sv    <= issue;
            r_sscan <= (r_state == B_SCAN);
            if (r_state == B_UWAIT) begin
                r_layer <= !r_layer;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_min_cost = r_out_cost;
    assign o_found    = r_out_found;
    assign o_overflow = r_out_ovf;

    a_ovf_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_ovf && r_out_found))
        else $error("overflow row reported as found");

    a_cost_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_cost == '0))
        else $error("nonzero cost on a row without a coloring");

    a_pop_valid_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_UPD) |-> i_q_valid)
        else $error("update running without a queued item");

endmodule
